// ----- hdl/lrp_pkg.sv -----
// Shared types, codes and defaults of the LR shift-reduce parser.
package lrp_pkg;

   localparam int STATE_W  = 8;
   localparam int SYMBOL_W = 6;
   localparam int VALUE_W  = 8;
   localparam int PROD_W   = 7;
   localparam int RHS_W    = 4;

   localparam int DEF_NUM_STATES      = 256;
   localparam int DEF_NUM_SYMBOLS     = 64;
   localparam int DEF_NUM_PRODUCTIONS = 128;
   localparam int DEF_STACK_DEPTH     = 64;
   localparam int DEF_MAX_RHS         = 15;
   localparam int DEF_MAX_REDUCTIONS  = 63;

   typedef enum logic [1:0] {
      OP_LOAD_ENTRY = 2'd0,
      OP_LOAD_PROD  = 2'd1,
      OP_TOKEN      = 2'd2,
      OP_RESTART    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ACT_EMPTY  = 2'd0,
      ACT_SHIFT  = 2'd1,
      ACT_REDUCE = 2'd2,
      ACT_ACCEPT = 2'd3
   } act_kind_type;

   typedef enum logic [2:0] {
      RES_ACK      = 3'd0,
      RES_REDUCED  = 3'd1,
      RES_SHIFTED  = 3'd2,
      RES_ACCEPTED = 3'd3,
      RES_ERROR    = 3'd4
   } res_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_NO_ENTRY  = 3'd1,
      ERR_OVERFLOW  = 3'd2,
      ERR_UNDERFLOW = 3'd3,
      ERR_RED_LIMIT = 3'd4,
      ERR_ENDED     = 3'd5
   } err_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_LOOK,
      ST_DECIDE,
      ST_PROD,
      ST_BELOW,
      ST_GOTO
   } fsm_type;

   typedef struct packed {
      act_kind_type        kind;
      logic [VALUE_W-1:0]  value;
   } act_entry_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] lhs;
      logic [RHS_W-1:0]    len;
   } prod_entry_type;

   typedef struct packed {
      logic                en;
      logic [STATE_W-1:0]  state;
      logic [SYMBOL_W-1:0] symbol;
   } act_rd_type;

   typedef struct packed {
      logic                en;
      logic [STATE_W-1:0]  state;
      logic [SYMBOL_W-1:0] symbol;
      act_entry_type       entry;
   } act_wr_type;

endpackage

// ----- hdl/lrp_if.sv -----
// Request and response channel interfaces of the LR shift-reduce parser.
interface lrp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] entry_state;
   logic [5:0] symbol;
   logic [1:0] action_kind;
   logic [7:0] action_value;
   logic [6:0] production_id;
   logic [5:0] lhs_symbol;
   logic [3:0] rhs_length;

   modport source (
      output valid, opcode, entry_state, symbol, action_kind, action_value,
             production_id, lhs_symbol, rhs_length,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_state, symbol, action_kind, action_value,
             production_id, lhs_symbol, rhs_length,
      output ready
   );
endinterface

interface lrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [6:0] reduced_production;
   logic [5:0] reduced_lhs;
   logic [7:0] new_state;
   logic [2:0] error_code;
   logic       last;

   modport source (
      output valid, result_kind, reduced_production, reduced_lhs, new_state,
             error_code, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, reduced_production, reduced_lhs, new_state,
             error_code, last,
      output ready
   );
endinterface

// ----- hdl/lrp_action_table.sv -----
// Action/goto table memory with a clearing sweep after reset.
module lrp_action_table #(
   parameter int NUM_STATES  = lrp_pkg::DEF_NUM_STATES,
   parameter int NUM_SYMBOLS = lrp_pkg::DEF_NUM_SYMBOLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrp_pkg::act_wr_type    wr,
   input  lrp_pkg::act_rd_type    rd,
   output lrp_pkg::act_entry_type rd_entry,
   output logic                   clearing
);
   import lrp_pkg::*;

   localparam int DEPTH = NUM_STATES * NUM_SYMBOLS;
   localparam int AW    = $clog2(DEPTH);

   act_entry_type mem [DEPTH];
   act_entry_type rd_data_ff;
   logic          rd_hit_ff;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_hit, rd_hit;

   function automatic logic [AW-1:0] entry_addr(input logic [STATE_W-1:0] st,
                                                input logic [SYMBOL_W-1:0] sy);
      return AW'(32'(st) * NUM_SYMBOLS + 32'(sy));
   endfunction

   assign wr_hit  = wr.en && (32'(wr.state) < NUM_STATES) && (32'(wr.symbol) < NUM_SYMBOLS);
   assign rd_hit  = (32'(rd.state) < NUM_STATES) && (32'(rd.symbol) < NUM_SYMBOLS);
   assign wr_addr = entry_addr(wr.state, wr.symbol);
   assign rd_addr = entry_addr(rd.state, rd.symbol);

   always_comb begin
      clr_addr_in = clr_addr_ff + AW'(1);
      clearing_in = clearing_ff && (clr_addr_ff != AW'(DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_hit) begin
         mem[wr_addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= rd_hit;
      end
   end

   assign rd_entry = rd_hit_ff ? rd_data_ff : '0;
   assign clearing = clearing_ff;

endmodule

// ----- hdl/lrp_prod_table.sv -----
// Production table memory: left symbol and right length per production.
module lrp_prod_table #(
   parameter int NUM_PRODUCTIONS = lrp_pkg::DEF_NUM_PRODUCTIONS
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [6:0]              wr_idx,
   input  lrp_pkg::prod_entry_type wr_entry,
   input  logic                    rd_en,
   input  logic [6:0]              rd_idx,
   output lrp_pkg::prod_entry_type rd_entry
);
   import lrp_pkg::*;

   localparam int PW = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;

   prod_entry_type mem [NUM_PRODUCTIONS];
   prod_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[PW'(wr_idx)] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[PW'(rd_idx)];
      end
   end

   assign rd_entry = rd_data_ff;

endmodule

// ----- hdl/lrp_state_stack.sv -----
// Parser state stack memory; the bottom entry always reads as state 0.
module lrp_state_stack #(
   parameter int STACK_DEPTH = lrp_pkg::DEF_STACK_DEPTH
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(STACK_DEPTH)-1:0] wr_idx,
   input  logic [lrp_pkg::STATE_W-1:0]    wr_state,
   input  logic                           rd_en,
   input  logic [$clog2(STACK_DEPTH)-1:0] rd_idx,
   output logic [lrp_pkg::STATE_W-1:0]    rd_state
);
   import lrp_pkg::*;

   logic [STATE_W-1:0] mem [STACK_DEPTH];
   logic [STATE_W-1:0] rd_data_ff;
   logic               rd_bottom_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_state;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff   <= mem[rd_idx];
         rd_bottom_ff <= (rd_idx == '0);
      end
   end

   assign rd_state = rd_bottom_ff ? '0 : rd_data_ff;

endmodule

// ----- hdl/lr_shift_reduce_parser_top.sv -----
// Top level of the table-driven LR shift-reduce parser.
//
// After reset the block sweeps all NUM_STATES*NUM_SYMBOLS entries (16384 by
// default) of the action/goto table to empty, one entry per cycle, and takes
// no item until the sweep is done. A load or restart item, or a token after
// the parse has ended, passes through ACK. A token passes through LOOK and
// DECIDE for its shift, accept or error result, and PROD, BELOW, GOTO, LOOK
// and DECIDE for each reduction before it: every reduction walks the action
// table read, the production table read, the stack read of the exposed state
// and the goto read of the table, all registered synchronous memories. An
// underflow ends in PROD, and a missing goto or a goto overflow in GOTO.
// Results leave through an output register, so a new item is taken while the
// last result waits; a stalled result holds the sequencer at its next result.
module lr_shift_reduce_parser_top #(
   parameter int NUM_STATES      = lrp_pkg::DEF_NUM_STATES,
   parameter int NUM_SYMBOLS     = lrp_pkg::DEF_NUM_SYMBOLS,
   parameter int NUM_PRODUCTIONS = lrp_pkg::DEF_NUM_PRODUCTIONS,
   parameter int STACK_DEPTH     = lrp_pkg::DEF_STACK_DEPTH,
   parameter int MAX_RHS         = lrp_pkg::DEF_MAX_RHS,
   parameter int MAX_REDUCTIONS  = lrp_pkg::DEF_MAX_REDUCTIONS
) (
   input logic       clock,
   input logic       reset,
   lrp_req_if.sink   req,
   lrp_rsp_if.source rsp
);
   import lrp_pkg::*;

   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int IW  = $clog2(STACK_DEPTH);
   localparam int NW  = $clog2(MAX_REDUCTIONS + 1);

   fsm_type             state_ff, state_in;
   opcode_type          op_ff;
   logic [STATE_W-1:0]  est_ff;
   logic [SYMBOL_W-1:0] sym_ff;
   logic [1:0]          akind_ff;
   logic [VALUE_W-1:0]  aval_ff;
   logic [PROD_W-1:0]   pid_ff;
   logic [SYMBOL_W-1:0] lhs_ff;
   logic [RHS_W-1:0]    rlen_ff;

   logic [SPW-1:0]      sp_ff, sp_in, newsp_ff, newsp_in;
   logic [STATE_W-1:0]  top_ff, top_in;
   logic                ended_ff, ended_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SYMBOL_W-1:0] plhs_ff, plhs_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_kind_ff, rsp_kind_in;
   logic [PROD_W-1:0]   rsp_prod_ff, rsp_prod_in;
   logic [SYMBOL_W-1:0] rsp_lhs_ff, rsp_lhs_in;
   logic [STATE_W-1:0]  rsp_state_ff, rsp_state_in;
   logic [2:0]          rsp_err_ff, rsp_err_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_accept, out_free, clearing;
   logic                reduce_ok, pop_ok, goto_ok;
   logic                emit, err_flag, e_last;
   res_kind_type        e_kind;
   err_code_type        e_err;
   logic [PROD_W-1:0]   e_prod;
   logic [SYMBOL_W-1:0] e_lhs;
   logic [STATE_W-1:0]  e_state;

   act_rd_type          act_rd;
   act_wr_type          act_wr;
   act_entry_type       act_q;
   logic                prod_wr_en, prod_rd_en;
   prod_entry_type      prod_wr_entry, prod_q;
   logic                stk_wr_en, stk_rd_en;
   logic [IW-1:0]       stk_wr_idx, stk_rd_idx;
   logic [STATE_W-1:0]  stk_wr_state, stk_q;

   lrp_action_table #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_action (
      .clock    (clock),
      .reset    (reset),
      .wr       (act_wr),
      .rd       (act_rd),
      .rd_entry (act_q),
      .clearing (clearing)
   );

   lrp_prod_table #(
      .NUM_PRODUCTIONS (NUM_PRODUCTIONS)
   ) u_prod (
      .clock    (clock),
      .wr_en    (prod_wr_en),
      .wr_idx   (pid_ff),
      .wr_entry (prod_wr_entry),
      .rd_en    (prod_rd_en),
      .rd_idx   (prod_in),
      .rd_entry (prod_q)
   );

   lrp_state_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .wr_en    (stk_wr_en),
      .wr_idx   (stk_wr_idx),
      .wr_state (stk_wr_state),
      .rd_en    (stk_rd_en),
      .rd_idx   (stk_rd_idx),
      .rd_state (stk_q)
   );

   assign req.ready  = (state_ff == ST_IDLE) && !clearing;
   assign req_accept = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   assign reduce_ok = (n_ff < NW'(MAX_REDUCTIONS)) && (32'(act_q.value) < NUM_PRODUCTIONS);
   assign pop_ok    = 32'(prod_q.len) < 32'(sp_ff);
   assign goto_ok   = (act_q.kind == ACT_SHIFT) && (32'(newsp_ff) < STACK_DEPTH);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (opcode_type'(req.opcode) == OP_TOKEN && !ended_ff) ? ST_LOOK
                                                                              : ST_ACK;
            end
         end
         ST_ACK: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_LOOK: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (out_free) begin
               state_in = (act_q.kind == ACT_REDUCE && reduce_ok) ? ST_PROD : ST_IDLE;
            end
         end
         ST_PROD: begin
            if (out_free) state_in = pop_ok ? ST_BELOW : ST_IDLE;
         end
         ST_BELOW: state_in = ST_GOTO;
         ST_GOTO: begin
            if (out_free) state_in = goto_ok ? ST_LOOK : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sp_in    = sp_ff;
      newsp_in = newsp_ff;
      top_in   = top_ff;
      ended_in = ended_ff;
      n_in     = req_accept ? '0 : n_ff;
      prod_in  = prod_ff;
      plhs_in  = plhs_ff;

      emit     = 1'b0;
      err_flag = 1'b0;
      e_kind   = RES_ACK;
      e_err    = ERR_NONE;
      e_prod   = '0;
      e_lhs    = '0;
      e_state  = top_ff;
      e_last   = 1'b1;

      act_rd.en     = 1'b0;
      act_rd.state  = top_ff;
      act_rd.symbol = sym_ff;

      act_wr.en           = 1'b0;
      act_wr.state        = est_ff;
      act_wr.symbol       = sym_ff;
      act_wr.entry.kind   = act_kind_type'(akind_ff);
      act_wr.entry.value  = aval_ff;

      prod_wr_en        = 1'b0;
      prod_wr_entry.lhs = lhs_ff;
      prod_wr_entry.len = (32'(rlen_ff) > MAX_RHS) ? RHS_W'(MAX_RHS) : rlen_ff;
      prod_rd_en        = 1'b0;

      stk_wr_en    = 1'b0;
      stk_wr_idx   = IW'(sp_ff);
      stk_wr_state = act_q.value;
      stk_rd_en    = 1'b0;
      stk_rd_idx   = '0;

      case (state_ff)
         ST_ACK: begin
            if (out_free) begin
               emit = 1'b1;
               case (op_ff)
                  OP_LOAD_ENTRY: act_wr.en = 1'b1;
                  OP_LOAD_PROD:  prod_wr_en = (32'(pid_ff) < NUM_PRODUCTIONS);
                  OP_RESTART: begin
                     sp_in    = SPW'(1);
                     top_in   = '0;
                     ended_in = 1'b0;
                     e_state  = '0;
                  end
                  OP_TOKEN: begin
                     e_kind = RES_ERROR;
                     e_err  = ERR_ENDED;
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         ST_LOOK: act_rd.en = 1'b1;
         ST_DECIDE: begin
            if (out_free) begin
               case (act_q.kind)
                  ACT_EMPTY: begin
                     err_flag = 1'b1;
                     e_err    = ERR_NO_ENTRY;
                  end
                  ACT_SHIFT: begin
                     if (32'(sp_ff) >= STACK_DEPTH) begin
                        err_flag = 1'b1;
                        e_err    = ERR_OVERFLOW;
                     end else begin
                        stk_wr_en = 1'b1;
                        sp_in     = sp_ff + SPW'(1);
                        top_in    = act_q.value;
                        emit      = 1'b1;
                        e_kind    = RES_SHIFTED;
                        e_state   = act_q.value;
                     end
                  end
                  ACT_ACCEPT: begin
                     ended_in = 1'b1;
                     emit     = 1'b1;
                     e_kind   = RES_ACCEPTED;
                  end
                  ACT_REDUCE: begin
                     if (n_ff >= NW'(MAX_REDUCTIONS)) begin
                        err_flag = 1'b1;
                        e_err    = ERR_RED_LIMIT;
                     end else if (!reduce_ok) begin
                        err_flag = 1'b1;
                        e_err    = ERR_NO_ENTRY;
                     end else begin
                        prod_rd_en = 1'b1;
                        prod_in    = PROD_W'(act_q.value);
                     end
                  end
                  default: err_flag = 1'b0;
               endcase
            end
         end
         ST_PROD: begin
            if (out_free) begin
               if (!pop_ok) begin
                  err_flag = 1'b1;
                  e_err    = ERR_UNDERFLOW;
               end else begin
                  newsp_in   = sp_ff - SPW'(prod_q.len);
                  stk_rd_en  = 1'b1;
                  stk_rd_idx = IW'(newsp_in - SPW'(1));
                  plhs_in    = prod_q.lhs;
               end
            end
         end
         ST_BELOW: begin
            act_rd.en     = 1'b1;
            act_rd.state  = stk_q;
            act_rd.symbol = plhs_ff;
         end
         ST_GOTO: begin
            if (out_free) begin
               if (act_q.kind != ACT_SHIFT) begin
                  err_flag = 1'b1;
                  e_err    = ERR_NO_ENTRY;
               end else if (!goto_ok) begin
                  err_flag = 1'b1;
                  e_err    = ERR_OVERFLOW;
               end else begin
                  stk_wr_en  = 1'b1;
                  stk_wr_idx = IW'(newsp_ff);
                  sp_in      = newsp_ff + SPW'(1);
                  top_in     = act_q.value;
                  n_in       = n_ff + NW'(1);
                  emit       = 1'b1;
                  e_kind     = RES_REDUCED;
                  e_prod     = prod_ff;
                  e_lhs      = plhs_ff;
                  e_state    = act_q.value;
                  e_last     = 1'b0;
               end
            end
         end
         default: emit = 1'b0;
      endcase

      if (err_flag) begin
         emit     = 1'b1;
         e_kind   = RES_ERROR;
         e_state  = top_ff;
         ended_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_prod_in  = rsp_prod_ff;
      rsp_lhs_in   = rsp_lhs_ff;
      rsp_state_in = rsp_state_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = e_kind;
         rsp_prod_in  = e_prod;
         rsp_lhs_in   = e_lhs;
         rsp_state_in = e_state;
         rsp_err_in   = e_err;
         rsp_last_in  = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= SPW'(1);
         top_ff       <= '0;
         ended_ff     <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         top_ff       <= top_in;
         ended_ff     <= ended_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= opcode_type'(req.opcode);
         est_ff   <= req.entry_state;
         sym_ff   <= req.symbol;
         akind_ff <= req.action_kind;
         aval_ff  <= req.action_value;
         pid_ff   <= req.production_id;
         lhs_ff   <= req.lhs_symbol;
         rlen_ff  <= req.rhs_length;
      end
      newsp_ff     <= newsp_in;
      prod_ff      <= prod_in;
      plhs_ff      <= plhs_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_prod_ff  <= rsp_prod_in;
      rsp_lhs_ff   <= rsp_lhs_in;
      rsp_state_ff <= rsp_state_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.result_kind        = rsp_kind_ff;
   assign rsp.reduced_production = rsp_prod_ff;
   assign rsp.reduced_lhs        = rsp_lhs_ff;
   assign rsp.new_state          = rsp_state_ff;
   assign rsp.error_code         = rsp_err_ff;
   assign rsp.last               = rsp_last_ff;

endmodule

// ----- test/lr_shift_reduce_parser_checker.sv -----
// Checker for the LR shift-reduce parser: tracks its tables and stack and scores each result.
module lr_shift_reduce_parser_checker (
   input  logic clock,
   input  logic reset,
   lrp_req_if   req,
   lrp_rsp_if   rsp,
   output int   bad_results,
   output int   results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import lrp_pkg::*;

   localparam int NUM_STATES      = DEF_NUM_STATES;
   localparam int NUM_SYMBOLS     = DEF_NUM_SYMBOLS;
   localparam int NUM_PRODUCTIONS = DEF_NUM_PRODUCTIONS;
   localparam int STACK_DEPTH     = DEF_STACK_DEPTH;
   localparam int MAX_RHS         = DEF_MAX_RHS;
   localparam int MAX_REDUCTIONS  = DEF_MAX_REDUCTIONS;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      res_kind_type        kind;
      logic [PROD_W-1:0]   production;
      logic [SYMBOL_W-1:0] lhs;
      logic [STATE_W-1:0]  state;
      err_code_type        err;
      logic                last;
   } parse_result_type;

   act_entry_type      action_tab [NUM_STATES][NUM_SYMBOLS];
   prod_entry_type     prod_tab [NUM_PRODUCTIONS];
   logic [STATE_W-1:0] parse_stack [STACK_DEPTH];
   int unsigned        stack_count;
   bit                 parse_done;
   parse_result_type   parse_results [$];
   int                 fail_count;

   function automatic logic [STATE_W-1:0] top_state();
      return parse_stack[stack_count - 1];
   endfunction

   function automatic void post_result(res_kind_type kind, logic [PROD_W-1:0] production,
                                       logic [SYMBOL_W-1:0] lhs, logic [STATE_W-1:0] state,
                                       err_code_type err, logic last);
      parse_results.push_back('{kind, production, lhs, state, err, last});
   endfunction

   function automatic string show(parse_result_type r);
      return $sformatf("kind=%0d prod=%0d lhs=%0d state=%0d err=%0d last=%0d",
                       r.kind, r.production, r.lhs, r.state, r.err, r.last);
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endfunction

   task automatic parse_token(input logic [SYMBOL_W-1:0] sym);
      act_entry_type      act;
      act_entry_type      jump;
      prod_entry_type     rule;
      logic [STATE_W-1:0] cur_state;
      err_code_type       err;
      int unsigned        base;
      int                 reductions;
      bit                 finished;
      reductions = 0;
      finished   = 0;
      if (parse_done) begin
         post_result(RES_ERROR, '0, '0, top_state(), ERR_ENDED, 1'b1);
         return;
      end
      while (!finished) begin
         cur_state = top_state();
         act       = action_tab[cur_state][sym];
         err       = ERR_NONE;
         case (act.kind)
            ACT_EMPTY: begin
               err = ERR_NO_ENTRY;
            end
            ACT_SHIFT: begin
               if (stack_count >= STACK_DEPTH) begin
                  err = ERR_OVERFLOW;
               end else begin
                  parse_stack[stack_count] = act.value;
                  stack_count++;
                  post_result(RES_SHIFTED, '0, '0, act.value, ERR_NONE, 1'b1);
                  finished = 1;
               end
            end
            ACT_ACCEPT: begin
               parse_done = 1;
               post_result(RES_ACCEPTED, '0, '0, cur_state, ERR_NONE, 1'b1);
               finished = 1;
            end
            default: begin
               if (reductions >= MAX_REDUCTIONS) begin
                  err = ERR_RED_LIMIT;
               end else if (act.value >= NUM_PRODUCTIONS) begin
                  err = ERR_NO_ENTRY;
               end else begin
                  rule = prod_tab[act.value[PROD_W-1:0]];
                  if (rule.len >= stack_count) begin
                     err = ERR_UNDERFLOW;
                  end else begin
                     base = stack_count - rule.len;
                     jump = action_tab[parse_stack[base - 1]][rule.lhs];
                     if (jump.kind != ACT_SHIFT) begin
                        err = ERR_NO_ENTRY;
                     end else if (base >= STACK_DEPTH) begin
                        err = ERR_OVERFLOW;
                     end else begin
                        parse_stack[base] = jump.value;
                        stack_count       = base + 1;
                        post_result(RES_REDUCED, act.value[PROD_W-1:0], rule.lhs, jump.value,
                                    ERR_NONE, 1'b0);
                        reductions++;
                     end
                  end
               end
            end
         endcase
         if (err != ERR_NONE) begin
            parse_done = 1;
            post_result(RES_ERROR, '0, '0, cur_state, err, 1'b1);
            finished = 1;
         end
      end
   endtask

   always @(posedge clock) begin
      parse_result_type got;
      parse_result_type want;
      if (reset) begin
         foreach (action_tab[s, t]) action_tab[s][t] = '{ACT_EMPTY, '0};
         foreach (prod_tab[p]) prod_tab[p] = '0;
         foreach (parse_stack[i]) parse_stack[i] = '0;
         stack_count = 1;
         parse_done  = 0;
         fail_count  = 0;
         parse_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{res_kind_type'(rsp.result_kind), rsp.reduced_production, rsp.reduced_lhs,
                    rsp.new_state, err_code_type'(rsp.error_code), rsp.last};
            if (parse_results.size() == 0) begin
               note_failure($sformatf("parser result with nothing pending: %s", show(got)));
            end else begin
               want = parse_results.pop_front();
               if (got.kind !== want.kind || got.production !== want.production ||
                   got.lhs !== want.lhs || got.state !== want.state ||
                   got.err !== want.err || got.last !== want.last)
                  note_failure($sformatf("parser result mismatch: expected %s, got %s",
                                         show(want), show(got)));
            end
         end
         if (req.valid && req.ready) begin
            case (opcode_type'(req.opcode))
               OP_LOAD_ENTRY: begin
                  action_tab[req.entry_state][req.symbol] =
                     '{act_kind_type'(req.action_kind), req.action_value};
                  post_result(RES_ACK, '0, '0, top_state(), ERR_NONE, 1'b1);
               end
               OP_LOAD_PROD: begin
                  prod_tab[req.production_id] =
                     '{req.lhs_symbol,
                       (req.rhs_length > MAX_RHS) ? RHS_W'(MAX_RHS) : req.rhs_length};
                  post_result(RES_ACK, '0, '0, top_state(), ERR_NONE, 1'b1);
               end
               OP_RESTART: begin
                  foreach (parse_stack[i]) parse_stack[i] = '0;
                  stack_count = 1;
                  parse_done  = 0;
                  post_result(RES_ACK, '0, '0, '0, ERR_NONE, 1'b1);
               end
               default: begin
                  parse_token(req.symbol);
               end
            endcase
         end
      end
      bad_results <= fail_count;
      results_due <= parse_results.size();
   end

endmodule

// ----- test/lr_shift_reduce_parser_top_tb.sv -----
// Testbench top for the LR shift-reduce parser: stimulus, reset, clock and verdict.
module lr_shift_reduce_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrp_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = 400;
   localparam int CALM_FIRST   = 200;
   localparam int CALM_LAST    = 330;
   localparam int DEPTH_RUN    = DEF_STACK_DEPTH + 2;

   logic clock;
   logic reset;
   bit   calm;
   int   items_sent;
   int   item_goal;
   int   bad_results;
   int   results_due;
   int   cycle_count;
   int   known_prods [$];

   lrp_req_if req_ch ();
   lrp_rsp_if rsp_ch ();

   lr_shift_reduce_parser_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   lr_shift_reduce_parser_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .bad_results (bad_results),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 6);
      end
   end

   task automatic send_item(input opcode_type op, input logic [7:0] est,
                            input logic [5:0] sym, input act_kind_type kind,
                            input logic [7:0] value, input logic [6:0] pid,
                            input logic [5:0] lhs, input logic [3:0] len);
      while (!calm && $urandom_range(99) < 6) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      calm                 <= (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= op;
      req_ch.entry_state   <= est;
      req_ch.symbol        <= sym;
      req_ch.action_kind   <= kind;
      req_ch.action_value  <= value;
      req_ch.production_id <= pid;
      req_ch.lhs_symbol    <= lhs;
      req_ch.rhs_length    <= len;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic put_entry(input logic [7:0] est, input logic [5:0] sym,
                            input act_kind_type kind, input logic [7:0] value);
      send_item(OP_LOAD_ENTRY, est, sym, kind, value, 7'($urandom_range(127)),
                6'($urandom_range(63)), 4'($urandom_range(15)));
   endtask

   task automatic put_rule(input logic [6:0] pid, input logic [5:0] lhs, input logic [3:0] len);
      send_item(OP_LOAD_PROD, 8'($urandom_range(255)), 6'($urandom_range(63)),
                act_kind_type'($urandom_range(3)), 8'($urandom_range(255)), pid, lhs, len);
      known_prods.push_back(pid);
   endtask

   task automatic feed_token(input logic [5:0] sym);
      send_item(OP_TOKEN, 8'($urandom_range(255)), sym, act_kind_type'($urandom_range(3)),
                8'($urandom_range(255)), 7'($urandom_range(127)), 6'($urandom_range(63)),
                4'($urandom_range(15)));
   endtask

   task automatic restart_parse();
      send_item(OP_RESTART, 8'($urandom_range(255)), 6'($urandom_range(63)),
                act_kind_type'($urandom_range(3)), 8'($urandom_range(255)),
                7'($urandom_range(127)), 6'($urandom_range(63)), 4'($urandom_range(15)));
   endtask

   // reduce only by a loaded production, or by one past the table
   function automatic logic [7:0] reduce_target();
      if ($urandom_range(9) == 0)
         return 8'($urandom_range(255, DEF_NUM_PRODUCTIONS));
      return 8'(known_prods[$urandom_range(known_prods.size() - 1)]);
   endfunction

   task automatic grammar_round();
      logic [7:0]   states [5];
      logic [5:0]   terms [3];
      logic [5:0]   nonterms [2];
      logic [6:0]   rules [3];
      act_kind_type kind;
      int           roll;
      states[0] = '0;
      for (int i = 1; i < 5; i++) states[i] = 8'($urandom_range(255));
      foreach (terms[i]) terms[i] = 6'($urandom_range(63));
      foreach (nonterms[i]) nonterms[i] = 6'($urandom_range(63));
      foreach (rules[i]) begin
         rules[i] = 7'($urandom_range(127));
         put_rule(rules[i], nonterms[$urandom_range(1)],
                  ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3)));
      end
      foreach (states[s]) begin
         foreach (nonterms[n]) begin
            if ($urandom_range(9) != 0)
               put_entry(states[s], nonterms[n], ACT_SHIFT, states[$urandom_range(4)]);
            else
               put_entry(states[s], nonterms[n], ACT_EMPTY, 8'($urandom_range(255)));
         end
         foreach (terms[t]) begin
            roll = $urandom_range(99);
            if (roll < 45)
               put_entry(states[s], terms[t], ACT_SHIFT, states[$urandom_range(4)]);
            else if (roll < 78)
               put_entry(states[s], terms[t], ACT_REDUCE,
                         (roll < 74) ? 8'(rules[$urandom_range(2)]) : reduce_target());
            else if (roll < 86)
               put_entry(states[s], terms[t], ACT_ACCEPT, 8'($urandom_range(255)));
            else
               put_entry(states[s], terms[t], ACT_EMPTY, 8'($urandom_range(255)));
         end
      end
      repeat ($urandom_range(3, 6)) begin
         restart_parse();
         repeat ($urandom_range(2, 14)) begin
            if (items_sent >= item_goal)
               return;
            roll = $urandom_range(99);
            if (roll < 3) begin
               kind = act_kind_type'($urandom_range(3));
               put_entry(8'($urandom_range(255)), 6'($urandom_range(63)), kind,
                         (kind == ACT_REDUCE) ? reduce_target() : 8'($urandom_range(255)));
            end else if (roll < 5) begin
               restart_parse();
            end else if (roll < 12) begin
               feed_token(6'($urandom_range(63)));
            end else begin
               feed_token(terms[$urandom_range(2)]);
            end
         end
      end
   endtask

   // fill the stack by self-looping shifts until it overflows
   task automatic deep_round();
      logic [7:0] loop_state;
      logic [5:0] sym;
      loop_state = 8'($urandom_range(255, 1));
      sym        = 6'($urandom_range(63));
      put_entry(8'd0, sym, ACT_SHIFT, loop_state);
      put_entry(loop_state, sym, ACT_SHIFT, loop_state);
      restart_parse();
      repeat (DEPTH_RUN) feed_token(sym);
   endtask

   initial begin
      items_sent            = 0;
      item_goal             = 0;
      reset                <= 1'b1;
      calm                 <= 1'b0;
      req_ch.valid         <= 1'b0;
      req_ch.opcode        <= OP_LOAD_ENTRY;
      req_ch.entry_state   <= '0;
      req_ch.symbol        <= '0;
      req_ch.action_kind   <= ACT_EMPTY;
      req_ch.action_value  <= '0;
      req_ch.production_id <= '0;
      req_ch.lhs_symbol    <= '0;
      req_ch.rhs_length    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // accept, then a token after the end
      put_entry(8'd0, 6'd6, ACT_ACCEPT, 8'd0);
      feed_token(6'd6);
      feed_token(6'd63);
      restart_parse();
      put_rule(7'd127, 6'd63, 4'd15);
      put_rule(7'd0, 6'd5, 4'd0);
      put_rule(7'd1, 6'd40, 4'd1);
      // empty reductions from a self goto overflow the stack
      put_entry(8'd0, 6'd63, ACT_SHIFT, 8'd255);
      put_entry(8'd255, 6'd63, ACT_REDUCE, 8'd0);
      put_entry(8'd255, 6'd5, ACT_SHIFT, 8'd255);
      feed_token(6'd63);
      feed_token(6'd63);
      // same loop from state 0 hits the reduction limit
      restart_parse();
      put_entry(8'd0, 6'd1, ACT_REDUCE, 8'd0);
      put_entry(8'd0, 6'd5, ACT_SHIFT, 8'd0);
      feed_token(6'd1);
      // underflow
      restart_parse();
      put_entry(8'd0, 6'd2, ACT_REDUCE, 8'd127);
      feed_token(6'd2);
      // production index past the table
      restart_parse();
      put_entry(8'd0, 6'd3, ACT_REDUCE, 8'd200);
      feed_token(6'd3);
      // missing goto
      restart_parse();
      put_entry(8'd0, 6'd4, ACT_SHIFT, 8'd7);
      put_entry(8'd7, 6'd4, ACT_REDUCE, 8'd1);
      feed_token(6'd4);
      feed_token(6'd4);

      item_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < item_goal) begin
         if ($urandom_range(5) == 0)
            deep_round();
         else
            grammar_round();
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_results == 0 && results_due == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
